>>> hdl/plt_pkg.sv
package plt_pkg;

	// List geometry.
	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Operation codes.
	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_POP_BACK   = 3'd1;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_INSERT     = 3'd4;
	localparam logic [2:0] OP_ERASE      = 3'd5;
	localparam logic [2:0] OP_FIND       = 3'd6;
	localparam logic [2:0] OP_CLEAR      = 3'd7;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// Request beat.
	typedef struct packed {
		logic [2:0]                  opcode;
		logic [CNT_W-1:0]            position;
		logic signed [WORD_BITS-1:0] value;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] found_index;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic init_walk;
		logic walk_en;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_needed;
		logic walk_done;
	} sts_t;

endpackage

>>> hdl/positional_list_table_top.sv
// Ordered list of up to 64 signed 32-bit words with push/pop at either end,
// insert and erase at a position, find and clear; every request beat gives
// exactly one response beat with a status, the match index and the new count.
// Requests are handled one at a time. Push back, pop back, clear and any
// request that fails its checks go from the check state straight to the
// state that writes the response register. Insert, erase, push front, pop
// front and find first walk the stored words through the single-ported read
// side of the list memory, one word per cycle, moving or comparing at most
// 64 words. A new request is taken once the previous one has been placed in
// the response register, even while that response is still waiting.
module positional_list_table_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  plt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output plt_pkg::rsp_t rsp
);

	import plt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	plt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// List storage, count and response payload.
	plt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

>>> hdl/plt_ram.sv
module plt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/plt_dp.sv
module plt_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  plt_pkg::req_t req,
	input  plt_pkg::cmd_t cmd,
	output plt_pkg::sts_t sts,
	output plt_pkg::rsp_t rsp
);

	import plt_pkg::*;

	req_t                 item_q;
	rsp_t                 rsp_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     rem_q;
	logic                 rv_s1;
	logic [ADDR_W-1:0]    raddr_s1;
	logic                 found_q;
	logic [ADDR_W-1:0]    fidx_q;

	logic [2:0]           op;
	logic [CNT_W-1:0]     eff_pos;
	logic [2:0]           err_st;
	logic                 err_hit;
	logic                 is_ins;
	logic                 is_ers;
	logic                 is_find;
	logic [CNT_W-1:0]     count_nx;
	logic [WORD_BITS-1:0] rdata;
	logic                 hit;
	logic                 issue;
	logic                 wwalk;
	logic                 wcommit;
	logic [ADDR_W-1:0]    waddr_walk;
	logic [ADDR_W-1:0]    waddr_commit;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;

	// Decode the held item. Front operations work at position zero.
	assign op      = item_q.opcode;
	assign is_ins  = (op == OP_PUSH_FRONT) || (op == OP_INSERT);
	assign is_ers  = (op == OP_POP_FRONT) || (op == OP_ERASE);
	assign is_find = (op == OP_FIND);
	assign eff_pos = ((op == OP_PUSH_FRONT) || (op == OP_POP_FRONT)) ? '0 : item_q.position;

	// Error checks against the current count, in the order the list defines.
	always_comb begin
		err_st = ST_OK;
		unique case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (count_q == CNT_W'(DEPTH)) err_st = ST_FULL;
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (count_q == '0) err_st = ST_EMPTY;
			end
			OP_INSERT: begin
				priority if (eff_pos > count_q) err_st = ST_BADPOS;
				else if (count_q == CNT_W'(DEPTH)) err_st = ST_FULL;
			end
			OP_ERASE: begin
				priority if (count_q == '0) err_st = ST_EMPTY;
				else if (eff_pos >= count_q) err_st = ST_BADPOS;
			end
			default: begin
				err_st = ST_OK;
			end
		endcase
	end

	assign err_hit = (err_st != ST_OK);

	// Count after the operation.
	always_comb begin
		count_nx = count_q;
		if (!err_hit) begin
			unique case (op)
				OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: count_nx = count_q + CNT_W'(1);
				OP_POP_BACK, OP_POP_FRONT, OP_ERASE:    count_nx = count_q - CNT_W'(1);
				OP_CLEAR:                               count_nx = '0;
				default:                                count_nx = count_q;
			endcase
		end
	end

	assign sts.walk_needed = !err_hit && (is_ins || is_ers || is_find);
	assign sts.walk_done   = (rem_q == '0) && !rv_s1;

	// Walk: one read per cycle, the returned word is moved one slot or compared.
	assign hit   = rv_s1 && is_find && (rdata == WORD_BITS'(item_q.value));
	assign issue = cmd.walk_en && (rem_q != '0) && !hit;
	assign wwalk = cmd.walk_en && rv_s1 && (is_ins || is_ers);
	assign waddr_walk = is_ins ? (raddr_s1 + ADDR_W'(1)) : (raddr_s1 - ADDR_W'(1));

	// Final write of the new word for push back and for the insert kinds.
	assign wcommit = cmd.commit && !err_hit && ((op == OP_PUSH_BACK) || is_ins);
	assign waddr_commit = (op == OP_PUSH_BACK) ? count_q[ADDR_W-1:0] : eff_pos[ADDR_W-1:0];

	assign ram_we    = wwalk || wcommit;
	assign ram_waddr = wcommit ? waddr_commit : waddr_walk;
	assign ram_wdata = wcommit ? WORD_BITS'(item_q.value) : rdata;

	plt_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// Control state of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			rv_s1   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cmd.init_walk) begin
				rv_s1   <= 1'b0;
				found_q <= 1'b0;
				if (is_ins) begin
					rem_q <= count_q - eff_pos;
				end else if (is_ers) begin
					rem_q <= count_q - eff_pos - CNT_W'(1);
				end else begin
					rem_q <= count_q;
				end
			end else if (cmd.walk_en) begin
				rv_s1 <= issue;
				if (hit) begin
					rem_q   <= '0;
					found_q <= 1'b1;
				end else if (issue) begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				count_q <= count_nx;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.init_walk) begin
			if (is_ins) begin
				ptr_q <= count_q - CNT_W'(1);
			end else if (is_ers) begin
				ptr_q <= eff_pos + CNT_W'(1);
			end else begin
				ptr_q <= '0;
			end
		end else if (issue) begin
			ptr_q <= is_ins ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
		end
		if (issue) begin
			raddr_s1 <= ptr_q[ADDR_W-1:0];
		end
		if (cmd.walk_en && hit) begin
			fidx_q <= raddr_s1;
		end
		if (cmd.commit) begin
			if (err_hit) begin
				rsp_q.status <= err_st;
			end else if (is_find && !found_q) begin
				rsp_q.status <= ST_NOTFOUND;
			end else begin
				rsp_q.status <= ST_OK;
			end
			rsp_q.found_index <= (is_find && found_q) ? fidx_q : '0;
			rsp_q.entry_count <= count_nx;
		end
	end

	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the list depth");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(wwalk && wcommit))
		else $error("walk write and final write collide");

	a_found_is_find: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> is_find)
		else $error("match flag set outside a find");

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_walk |=> (!rv_s1 && !found_q))
		else $error("walk start left stale read or match state");
`endif

endmodule

>>> hdl/plt_ctrl.sv
module plt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  plt_pkg::sts_t sts,
	output plt_pkg::cmd_t cmd
);

	import plt_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_WALK   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;
	logic       slot_free;

	// The response register is free when empty or being drained this cycle.
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Sequencer: take a beat, check it, walk the list if needed, then report.
	always_comb begin
		state_nx      = state_q;
		cmd.capture   = 1'b0;
		cmd.init_walk = 1'b0;
		cmd.walk_en   = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.walk_needed) begin
					cmd.init_walk = 1'b1;
					state_nx      = S_WALK;
				end else begin
					state_nx = S_FINISH;
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_done) begin
					state_nx = S_FINISH;
				end
			end
			default: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
